@@ design/pbrr_pkg.sv @@
// Shared constants, codes and types of the bitmap round robin scheduler.
`timescale 1ns / 1ps
package pbrr_pkg;

   localparam int NUM_THREADS_DEF    = 32;
   localparam int NUM_LEVELS_DEF     = 32;
   localparam int NUM_WAIT_LISTS_DEF = 8;

   localparam int MODE_W   = 3;
   localparam int TID_W    = 5;
   localparam int PRIO_W   = 5;
   localparam int WLIST_W  = 3;
   localparam int STATUS_W = 2;

   localparam logic [MODE_W-1:0] MODE_ADD     = 3'd0;
   localparam logic [MODE_W-1:0] MODE_START   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_BLOCK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_UNBLOCK = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_READY    = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_WAIT_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_STARTED = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LINK,
      ST_PUSH,
      ST_FIX
   } pbrr_state_type;

endpackage

@@ design/pbrr_ram.sv @@
// Simple dual port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
module pbrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/priority_bitmap_round_robin_scheduler.sv @@
// Top level: command sequencer of the bitmap round robin scheduler.
// Steps per item after acceptance: READ (early exits), READ and LINK (start, tick),
// READ, LINK and FIX (add), READ, LINK, PUSH and FIX (block, unblock).
// Flow: one item at a time; a new item is taken only in idle once the previous result
// has been taken. The steps follow from the registered read port of the table RAMs.
// Reset (synchronous): no thread present, all levels and wait lists empty, not started.
`timescale 1ns / 1ps
module priority_bitmap_round_robin_scheduler #(
   parameter int NUM_THREADS    = pbrr_pkg::NUM_THREADS_DEF,
   parameter int NUM_LEVELS     = pbrr_pkg::NUM_LEVELS_DEF,
   parameter int NUM_WAIT_LISTS = pbrr_pkg::NUM_WAIT_LISTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], thread_id[7:3], priority_req[12:8], wait_list[15:13]
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // active_thread[4:0], active_valid[5], moved_thread[10:6], status[12:11], zero[15:13]
   output logic [15:0] rsp_tdata
);

   // Thread index width, link width (one extra code for "none"), level and list widths.
   localparam int TIDW  = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
   localparam int LINKW = $clog2(NUM_THREADS + 1);
   localparam int LVLW  = $clog2(NUM_LEVELS);
   localparam int WLW   = (NUM_WAIT_LISTS > 1) ? $clog2(NUM_WAIT_LISTS) : 1;
   localparam logic [LINKW-1:0] NIL = LINKW'(NUM_THREADS);

   // Sequencer state and the latched item.
   pbrr_pkg::pbrr_state_type state_ff, state_in;
   logic [pbrr_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [pbrr_pkg::TID_W-1:0]  tid_ff, tid_in;
   logic [LVLW-1:0]             lvl_ff, lvl_in;
   logic [WLW-1:0]              wl_ff, wl_in;
   logic [LINKW-1:0]            node_ff, node_in;

   // Scheduler state held in flops: small or needing a reset value.
   logic [LINKW-1:0]            cur_ff, cur_in;
   logic                        started_ff, started_in;
   logic [NUM_LEVELS-1:0]       map_ff, map_in;
   logic [NUM_THREADS-1:0]      present_ff, present_in;
   logic [LINKW-1:0]            wait_head_ff [NUM_WAIT_LISTS];
   logic [LINKW-1:0]            wait_head_in [NUM_WAIT_LISTS];

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [pbrr_pkg::TID_W-1:0]   rsp_active_ff, rsp_active_in;
   logic                         rsp_act_valid_ff, rsp_act_valid_in;
   logic [pbrr_pkg::TID_W-1:0]   rsp_moved_ff, rsp_moved_in;
   logic [pbrr_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // RAM ports: next link, previous link, thread level, level head.
   logic             next_we, prev_we, level_we, head_we;
   logic [TIDW-1:0]  next_waddr, prev_waddr, level_waddr, node_raddr;
   logic [LINKW-1:0] next_wdata, prev_wdata, head_wdata;
   logic [LVLW-1:0]  level_wdata, head_waddr, head_raddr;
   logic [LINKW-1:0] next_rd, prev_rd, head_rd;
   logic [LVLW-1:0]  level_rd;

   // Decode helpers.
   logic [LVLW-1:0]              top_lvl;
   logic                         map_any;
   logic [pbrr_pkg::WLIST_W-1:0] wl_mod;
   logic [LINKW-1:0]             h_link;
   logic                         finish;
   logic [LINKW-1:0]             fin_moved;
   logic [pbrr_pkg::STATUS_W-1:0] fin_status;

   pbrr_ram #(.WIDTH(LINKW), .DEPTH(NUM_THREADS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_addr (node_raddr),
      .rd_data (next_rd)
   );

   pbrr_ram #(.WIDTH(LINKW), .DEPTH(NUM_THREADS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_addr (node_raddr),
      .rd_data (prev_rd)
   );

   pbrr_ram #(.WIDTH(LVLW), .DEPTH(NUM_THREADS)) u_level_ram (
      .clock   (clock),
      .wr_en   (level_we),
      .wr_addr (level_waddr),
      .wr_data (level_wdata),
      .rd_addr (node_raddr),
      .rd_data (level_rd)
   );

   pbrr_ram #(.WIDTH(LINKW), .DEPTH(NUM_LEVELS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rd)
   );

   // Highest ready level: lowest set bit of the level map.
   always_comb begin
      top_lvl = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            top_lvl = LVLW'(i);
         end
      end
      map_any = |map_ff;
   end

   // Wait list number taken modulo the list count by repeated subtraction.
   always_comb begin
      wl_mod = req_tdata[15:13];
      for (int i = 0; i < 8; i++) begin
         if (int'(wl_mod) >= NUM_WAIT_LISTS) begin
            wl_mod = pbrr_pkg::WLIST_W'(int'(wl_mod) - NUM_WAIT_LISTS);
         end
      end
   end

   assign req_tready = (state_ff == pbrr_pkg::ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      tid_in     = tid_ff;
      lvl_in     = lvl_ff;
      wl_in      = wl_ff;
      node_in    = node_ff;
      cur_in     = cur_ff;
      started_in = started_ff;
      map_in     = map_ff;
      present_in = present_ff;
      wait_head_in = wait_head_ff;

      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_active_in    = rsp_active_ff;
      rsp_act_valid_in = rsp_act_valid_ff;
      rsp_moved_in     = rsp_moved_ff;
      rsp_status_in    = rsp_status_ff;

      next_we     = 1'b0;
      next_waddr  = '0;
      next_wdata  = NIL;
      prev_we     = 1'b0;
      prev_waddr  = '0;
      prev_wdata  = NIL;
      level_we    = 1'b0;
      level_waddr = '0;
      level_wdata = '0;
      head_we     = 1'b0;
      head_waddr  = '0;
      head_wdata  = NIL;
      node_raddr  = TIDW'(cur_ff);
      head_raddr  = lvl_ff;
      h_link      = NIL;

      finish     = 1'b0;
      fin_moved  = NIL;
      fin_status = pbrr_pkg::STAT_OK;

      case (state_ff)
         pbrr_pkg::ST_IDLE: begin
            // Latch the item; saturate the level and wrap the wait list number.
            if (req_tvalid && req_tready) begin
               mode_in = req_tdata[2:0];
               tid_in  = req_tdata[7:3];
               if (int'(req_tdata[12:8]) >= NUM_LEVELS) begin
                  lvl_in = LVLW'(NUM_LEVELS - 1);
               end else begin
                  lvl_in = LVLW'(req_tdata[12:8]);
               end
               wl_in    = WLW'(wl_mod);
               state_in = pbrr_pkg::ST_READ;
            end
         end

         pbrr_pkg::ST_READ: begin
            // Check the early exits and issue the table reads.
            case (mode_ff)
               pbrr_pkg::MODE_ADD: begin
                  if (int'(tid_ff) >= NUM_THREADS || present_ff[TIDW'(tid_ff)]) begin
                     finish = 1'b1;
                  end else begin
                     node_in    = LINKW'(tid_ff);
                     head_raddr = lvl_ff;
                     state_in   = pbrr_pkg::ST_LINK;
                  end
               end
               pbrr_pkg::MODE_START: begin
                  started_in = 1'b1;
                  if (!map_any) begin
                     cur_in     = NIL;
                     fin_status = pbrr_pkg::STAT_NO_READY;
                     finish     = 1'b1;
                  end else begin
                     head_raddr = top_lvl;
                     state_in   = pbrr_pkg::ST_LINK;
                  end
               end
               pbrr_pkg::MODE_TICK: begin
                  if (!started_ff) begin
                     fin_status = pbrr_pkg::STAT_NOT_STARTED;
                     finish     = 1'b1;
                  end else if (!map_any) begin
                     cur_in     = NIL;
                     fin_status = pbrr_pkg::STAT_NO_READY;
                     finish     = 1'b1;
                  end else begin
                     node_raddr = TIDW'(cur_ff);
                     head_raddr = top_lvl;
                     state_in   = pbrr_pkg::ST_LINK;
                  end
               end
               pbrr_pkg::MODE_BLOCK: begin
                  if (!started_ff) begin
                     fin_status = pbrr_pkg::STAT_NOT_STARTED;
                     finish     = 1'b1;
                  end else if (cur_ff >= NIL) begin
                     fin_status = pbrr_pkg::STAT_NO_READY;
                     finish     = 1'b1;
                  end else begin
                     node_in    = cur_ff;
                     node_raddr = TIDW'(cur_ff);
                     state_in   = pbrr_pkg::ST_LINK;
                  end
               end
               pbrr_pkg::MODE_UNBLOCK: begin
                  if (wait_head_ff[wl_ff] >= NIL) begin
                     fin_status = pbrr_pkg::STAT_WAIT_EMPTY;
                     finish     = 1'b1;
                  end else begin
                     node_in    = wait_head_ff[wl_ff];
                     node_raddr = TIDW'(wait_head_ff[wl_ff]);
                     state_in   = pbrr_pkg::ST_LINK;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end

         pbrr_pkg::ST_LINK: begin
            case (mode_ff)
               pbrr_pkg::MODE_ADD: begin
                  // Push onto the head of the level list.
                  h_link = map_ff[lvl_ff] ? head_rd : NIL;
                  if (h_link < NIL) begin
                     prev_we    = 1'b1;
                     prev_waddr = TIDW'(h_link);
                     prev_wdata = node_ff;
                  end
                  next_we     = 1'b1;
                  next_waddr  = TIDW'(node_ff);
                  next_wdata  = h_link;
                  level_we    = 1'b1;
                  level_waddr = TIDW'(node_ff);
                  level_wdata = lvl_ff;
                  head_we     = 1'b1;
                  head_waddr  = lvl_ff;
                  head_wdata  = node_ff;
                  map_in[lvl_ff] = 1'b1;
                  present_in[TIDW'(node_ff)] = 1'b1;
                  state_in    = pbrr_pkg::ST_FIX;
               end
               pbrr_pkg::MODE_START: begin
                  cur_in = head_rd;
                  finish = 1'b1;
               end
               pbrr_pkg::MODE_TICK: begin
                  // Rotate within the level, wrap to its head, or jump to the top level.
                  if (cur_ff < NIL && level_rd == top_lvl) begin
                     cur_in = (next_rd < NIL) ? next_rd : head_rd;
                  end else begin
                     cur_in = head_rd;
                  end
                  finish = 1'b1;
               end
               pbrr_pkg::MODE_BLOCK: begin
                  // Unlink the active thread from its level list.
                  lvl_in = level_rd;
                  if (prev_rd < NIL) begin
                     next_we    = 1'b1;
                     next_waddr = TIDW'(prev_rd);
                     next_wdata = next_rd;
                  end else begin
                     head_we    = 1'b1;
                     head_waddr = level_rd;
                     head_wdata = next_rd;
                  end
                  if (next_rd < NIL) begin
                     prev_we    = 1'b1;
                     prev_waddr = TIDW'(next_rd);
                     prev_wdata = prev_rd;
                  end
                  if (prev_rd >= NIL && next_rd >= NIL) begin
                     map_in[level_rd] = 1'b0;
                  end
                  state_in = pbrr_pkg::ST_PUSH;
               end
               default: begin
                  // Unblock: pop the wait list head, then fetch the level head.
                  lvl_in = level_rd;
                  wait_head_in[wl_ff] = next_rd;
                  if (next_rd < NIL) begin
                     prev_we    = 1'b1;
                     prev_waddr = TIDW'(next_rd);
                     prev_wdata = NIL;
                  end
                  head_raddr = level_rd;
                  state_in   = pbrr_pkg::ST_PUSH;
               end
            endcase
         end

         pbrr_pkg::ST_PUSH: begin
            if (mode_ff == pbrr_pkg::MODE_BLOCK) begin
               h_link = wait_head_ff[wl_ff];
               wait_head_in[wl_ff] = node_ff;
               cur_in = NIL;
            end else begin
               h_link     = map_ff[lvl_ff] ? head_rd : NIL;
               head_we    = 1'b1;
               head_waddr = lvl_ff;
               head_wdata = node_ff;
               map_in[lvl_ff] = 1'b1;
            end
            if (h_link < NIL) begin
               prev_we    = 1'b1;
               prev_waddr = TIDW'(h_link);
               prev_wdata = node_ff;
            end
            next_we    = 1'b1;
            next_waddr = TIDW'(node_ff);
            next_wdata = h_link;
            state_in   = pbrr_pkg::ST_FIX;
         end

         pbrr_pkg::ST_FIX: begin
            // The moved thread is now a list head: clear its back link.
            prev_we    = 1'b1;
            prev_waddr = TIDW'(node_ff);
            prev_wdata = NIL;
            fin_moved  = node_ff;
            finish     = 1'b1;
         end

         default: begin
            state_in = pbrr_pkg::ST_IDLE;
         end
      endcase

      // Load the result register and return to idle.
      if (finish) begin
         state_in         = pbrr_pkg::ST_IDLE;
         rsp_valid_in     = 1'b1;
         rsp_act_valid_in = cur_in < NIL;
         rsp_active_in    = (cur_in < NIL) ? pbrr_pkg::TID_W'(cur_in) : '0;
         rsp_moved_in     = (fin_moved < NIL) ? pbrr_pkg::TID_W'(fin_moved) : '0;
         rsp_status_in    = fin_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pbrr_pkg::ST_IDLE;
         cur_ff       <= NIL;
         started_ff   <= 1'b0;
         map_ff       <= '0;
         present_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_WAIT_LISTS; i++) begin
            wait_head_ff[i] <= NIL;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         started_ff   <= started_in;
         map_ff       <= map_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         wait_head_ff <= wait_head_in;
      end
   end

   // Payload registers, no reset needed.
   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      tid_ff           <= tid_in;
      lvl_ff           <= lvl_in;
      wl_ff            <= wl_in;
      node_ff          <= node_in;
      rsp_active_ff    <= rsp_active_in;
      rsp_act_valid_ff <= rsp_act_valid_in;
      rsp_moved_ff     <= rsp_moved_in;
      rsp_status_ff    <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_status_ff, rsp_moved_ff, rsp_act_valid_ff, rsp_active_ff};

endmodule

@@ tb/tb_priority_bitmap_round_robin_scheduler.sv @@
// Testbench of the bitmap round robin scheduler, checked against a behavioral model.
`timescale 1ns / 1ps
module tb_priority_bitmap_round_robin_scheduler;

   localparam int NT = 32;
   localparam int NL = 32;
   localparam int NW = 8;
   localparam logic [5:0] NIL = 6'd32;

   typedef struct packed {
      logic [2:0] wait_list;
      logic [4:0] prio;
      logic [4:0] tid;
      logic [2:0] mode;
   } cmd_type;

   typedef struct packed {
      logic [2:0] zero;
      logic [1:0] status;
      logic [4:0] moved;
      logic       act_valid;
      logic [4:0] act;
   } sched_out_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // mode, thread_id, priority_req, wait_list
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // active_thread, active_valid, moved_thread, status, zero

   priority_bitmap_round_robin_scheduler DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Scheduler model state.
   logic [5:0]  lvl_head [NL];
   logic [31:0] lvl_map;
   logic [5:0]  nxt [NT];
   logic [5:0]  prv [NT];
   logic [4:0]  t_lvl [NT];
   logic        t_present [NT];
   logic [5:0]  w_head [NW];
   logic [5:0]  cur;
   logic        started;

   cmd_type       pending_cmds[$];
   sched_out_type expected_outs[$];
   int            mismatches;
   bit            send_pause;
   bit            long_hold_req;
   bit            long_hold_done;
   int            long_hold_left;
   int            hold_cycles;
   int            gap;
   int            in_taken;
   int            in_seen;

   function automatic int top_lvl();
      for (int i = 0; i < NL; i++) if (lvl_map[i]) return i;
      return NL;
   endfunction

   // Head pointers live in arrays; pass a selector and index.
   function automatic logic [5:0] get_head(bit is_wait, int i);
      return is_wait ? w_head[i] : lvl_head[i];
   endfunction

   function automatic void set_head(bit is_wait, int i, logic [5:0] v);
      if (is_wait) w_head[i] = v; else lvl_head[i] = v;
   endfunction

   function automatic void unlink(logic [5:0] t, bit is_wait, int i);
      logic [5:0] p, n;
      p = prv[t]; n = nxt[t];
      if (p < NIL) nxt[p] = n; else set_head(is_wait, i, n);
      if (n < NIL) prv[n] = p;
      nxt[t] = NIL; prv[t] = NIL;
   endfunction

   function automatic void push(logic [5:0] t, bit is_wait, int i);
      logic [5:0] h;
      h = get_head(is_wait, i);
      if (h < NIL) prv[h] = t;
      nxt[t] = h; prv[t] = NIL;
      set_head(is_wait, i, t);
   endfunction

   function automatic void sched_reset();
      for (int i = 0; i < NL; i++) lvl_head[i] = NIL;
      for (int i = 0; i < NT; i++) begin
         nxt[i] = NIL; prv[i] = NIL; t_lvl[i] = 0; t_present[i] = 0;
      end
      for (int i = 0; i < NW; i++) w_head[i] = NIL;
      lvl_map = 0; cur = NIL; started = 0;
   endfunction

   // Apply one command to the model and return the result item it yields.
   function automatic sched_out_type sched_step(cmd_type c);
      sched_out_type o;
      logic [5:0] moved, t;
      logic [1:0] st;
      int top, wl;
      moved = NIL; st = pbrr_pkg::STAT_OK; wl = c.wait_list % NW;
      case (c.mode)
         pbrr_pkg::MODE_ADD: begin
            if (!t_present[c.tid]) begin
               t_present[c.tid] = 1;
               t_lvl[c.tid] = c.prio;
               push({1'b0, c.tid}, 0, c.prio);
               lvl_map[c.prio] = 1;
               moved = {1'b0, c.tid};
            end
         end
         pbrr_pkg::MODE_START: begin
            started = 1;
            top = top_lvl();
            if (top < NL) cur = lvl_head[top];
            else begin cur = NIL; st = pbrr_pkg::STAT_NO_READY; end
         end
         pbrr_pkg::MODE_TICK: begin
            if (!started) st = pbrr_pkg::STAT_NOT_STARTED;
            else begin
               top = top_lvl();
               if (top >= NL) begin
                  cur = NIL; st = pbrr_pkg::STAT_NO_READY;
               end else if (cur < NIL && t_lvl[cur] == top) begin
                  t = nxt[cur];
                  cur = (t < NIL) ? t : lvl_head[top];
               end else cur = lvl_head[top];
            end
         end
         pbrr_pkg::MODE_BLOCK: begin
            if (!started) st = pbrr_pkg::STAT_NOT_STARTED;
            else if (cur >= NIL) st = pbrr_pkg::STAT_NO_READY;
            else begin
               t = cur;
               unlink(t, 0, t_lvl[t]);
               if (lvl_head[t_lvl[t]] >= NIL) lvl_map[t_lvl[t]] = 0;
               push(t, 1, wl);
               cur = NIL; moved = t;
            end
         end
         pbrr_pkg::MODE_UNBLOCK: begin
            t = w_head[wl];
            if (t >= NIL) st = pbrr_pkg::STAT_WAIT_EMPTY;
            else begin
               unlink(t, 1, wl);
               push(t, 0, t_lvl[t]);
               lvl_map[t_lvl[t]] = 1;
               moved = t;
            end
         end
         default: ;
      endcase
      o = '0;
      o.act_valid = cur < NIL;
      o.act = (cur < NIL) ? cur[4:0] : 5'd0;
      o.moved = (moved < NIL) ? moved[4:0] : 5'd0;
      o.status = st;
      return o;
   endfunction

   function automatic cmd_type mk(logic [2:0] m, int tid, int pr, int wl);
      cmd_type c;
      c.mode = m; c.tid = 5'(tid); c.prio = 5'(pr); c.wait_list = 3'(wl);
      return c;
   endfunction

   function automatic int rand_gap();
      return ($urandom_range(0, 9) < 6) ? 0 :
             ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // Driver: present pending items at the falling edge, with random gaps.
   always @(negedge clock) begin
      if (in_seen != in_taken) begin
         // an item was taken at the last rising edge
         in_seen = in_taken;
         gap = rand_gap();
      end
      if (reset || send_pause || pending_cmds.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (gap > 0) begin
         gap--;
         req_tvalid <= 1'b0;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata  <= pending_cmds[0];
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done = 1'b1;
         long_hold_left = 200;
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 9) < 3) hold_cycles = rand_gap();
      end
   end

   // Monitor: record taken input items, compare each taken result item with the
   // oldest expectation.
   always @(posedge clock) begin
      sched_out_type got, want;
      if (!reset && req_tvalid && req_tready) begin
         expected_outs.push_back(sched_step(cmd_type'(req_tdata)));
         void'(pending_cmds.pop_front());
         in_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_outs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item %h", rsp_tdata);
         end else begin
            want = expected_outs.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected act=%0d/%0d moved=%0d st=%0d,",
                            " got act=%0d/%0d moved=%0d st=%0d"},
                           want.act, want.act_valid, want.moved, want.status,
                           got.act, got.act_valid, got.moved, got.status);
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || expected_outs.size() != 0) @(posedge clock);
   endtask

   initial begin
      int n;
      mismatches = 0; send_pause = 0; long_hold_req = 0;
      sched_reset();
      reset = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: commands before start, empty wait list, empty start, then a small set.
      pending_cmds.push_back(mk(pbrr_pkg::MODE_TICK, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_BLOCK, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_UNBLOCK, 0, 0, 7));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_START, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_TICK, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_BLOCK, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_ADD, 31, 31, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_ADD, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_ADD, 5, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_ADD, 5, 3, 0));     // repeated add is ignored
      pending_cmds.push_back(mk(pbrr_pkg::MODE_START, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_TICK, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_TICK, 0, 0, 0));    // wrap to level head
      pending_cmds.push_back(mk(pbrr_pkg::MODE_BLOCK, 0, 0, 7));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_TICK, 0, 0, 0));    // tick after block
      pending_cmds.push_back(mk(pbrr_pkg::MODE_BLOCK, 0, 0, 7));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_UNBLOCK, 0, 0, 7));
      pending_cmds.push_back(mk(3'd5, 31, 31, 7));
      pending_cmds.push_back(mk(3'd7, 0, 0, 0));
      pending_cmds.push_back(mk(pbrr_pkg::MODE_TICK, 0, 0, 0));
      wait_drained();

      // Long receiver hold while the sender keeps offering items.
      long_hold_req = 1;
      for (int i = 0; i < 10; i++)
         pending_cmds.push_back(mk(pbrr_pkg::MODE_ADD, $urandom_range(0, 31),
                                   $urandom_range(0, 31), 0));
      wait_drained();

      // Random commands, mostly meaningful, with occasional sender pauses.
      n = 0;
      while (n < 600) begin
         int r;
         r = $urandom_range(0, 99);
         pending_cmds.push_back(mk(r < 25 ? pbrr_pkg::MODE_ADD :
                                   r < 35 ? pbrr_pkg::MODE_START :
                                   r < 65 ? pbrr_pkg::MODE_TICK :
                                   r < 80 ? pbrr_pkg::MODE_BLOCK :
                                   r < 97 ? pbrr_pkg::MODE_UNBLOCK :
                                   3'($urandom_range(5, 7)),
                                   $urandom_range(0, 31), $urandom_range(0, 31),
                                   $urandom_range(0, 7)));
         n++;
         if (n % 150 == 0) begin
            wait_drained();
            send_pause = 1;
            repeat ($urandom_range(5, 30)) @(posedge clock);
            send_pause = 0;
         end
      end
      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

@@ priority_bitmap_round_robin_scheduler.f @@
design/pbrr_pkg.sv
design/pbrr_ram.sv
design/priority_bitmap_round_robin_scheduler.sv
tb/tb_priority_bitmap_round_robin_scheduler.sv
